FILE: design/sppt_pkg.sv
// sppt_pkg: shared types, constants and the command decoder of the
// svg path point tracker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sppt_pkg;

  // field widths fixed by the stream format
  localparam int unsigned IN_WIDTH       = 32;
  localparam int unsigned OUT_WIDTH      = 32;
  localparam int unsigned CHAR_WIDTH     = 8;
  localparam int unsigned CNT_WIDTH      = 3;
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // arc parameter groups: seven values, end point at index five and six
  localparam logic [CNT_WIDTH-1:0] ARC_GROUP   = 3'd7;
  localparam logic [CNT_WIDTH-1:0] ARC_X_INDEX = 3'd5;
  localparam logic [CNT_WIDTH-1:0] ARC_Y_INDEX = 3'd6;

  // op codes of a request
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_PARAM   = 1'b1;

  // command letters
  localparam logic [CHAR_WIDTH-1:0] CHAR_M_ABS = "M";
  localparam logic [CHAR_WIDTH-1:0] CHAR_L_ABS = "L";
  localparam logic [CHAR_WIDTH-1:0] CHAR_C_ABS = "C";
  localparam logic [CHAR_WIDTH-1:0] CHAR_S_ABS = "S";
  localparam logic [CHAR_WIDTH-1:0] CHAR_Q_ABS = "Q";
  localparam logic [CHAR_WIDTH-1:0] CHAR_T_ABS = "T";
  localparam logic [CHAR_WIDTH-1:0] CHAR_M_REL = "m";
  localparam logic [CHAR_WIDTH-1:0] CHAR_L_REL = "l";
  localparam logic [CHAR_WIDTH-1:0] CHAR_C_REL = "c";
  localparam logic [CHAR_WIDTH-1:0] CHAR_S_REL = "s";
  localparam logic [CHAR_WIDTH-1:0] CHAR_Q_REL = "q";
  localparam logic [CHAR_WIDTH-1:0] CHAR_T_REL = "t";
  localparam logic [CHAR_WIDTH-1:0] CHAR_H_ABS = "H";
  localparam logic [CHAR_WIDTH-1:0] CHAR_H_REL = "h";
  localparam logic [CHAR_WIDTH-1:0] CHAR_V_ABS = "V";
  localparam logic [CHAR_WIDTH-1:0] CHAR_V_REL = "v";
  localparam logic [CHAR_WIDTH-1:0] CHAR_A_ABS = "A";
  localparam logic [CHAR_WIDTH-1:0] CHAR_A_REL = "a";

  typedef enum logic [3:0] {
    CLS_IGNORE,
    CLS_ABS_PAIR,
    CLS_REL_PAIR,
    CLS_H_ABS,
    CLS_H_REL,
    CLS_V_ABS,
    CLS_V_REL,
    CLS_ARC_ABS,
    CLS_ARC_REL
  } cls_e;

  // control going into the point unit
  typedef struct packed {
    cls_e                 cls;
    logic [CNT_WIDTH-1:0] cnt;
  } sppt_ctrl_t;

  // control coming back from the point unit
  typedef struct packed {
    logic                 emit;
    logic [CNT_WIDTH-1:0] cnt;
  } sppt_step_t;

  // command letter to class
  function automatic cls_e classify(logic [CHAR_WIDTH-1:0] ch);
    cls_e cls;
    unique case (ch)
      CHAR_M_ABS, CHAR_L_ABS, CHAR_C_ABS,
      CHAR_S_ABS, CHAR_Q_ABS, CHAR_T_ABS: cls = CLS_ABS_PAIR;
      CHAR_M_REL, CHAR_L_REL, CHAR_C_REL,
      CHAR_S_REL, CHAR_Q_REL, CHAR_T_REL: cls = CLS_REL_PAIR;
      CHAR_H_ABS: cls = CLS_H_ABS;
      CHAR_H_REL: cls = CLS_H_REL;
      CHAR_V_ABS: cls = CLS_V_ABS;
      CHAR_V_REL: cls = CLS_V_REL;
      CHAR_A_ABS: cls = CLS_ARC_ABS;
      CHAR_A_REL: cls = CLS_ARC_REL;
      default:    cls = CLS_IGNORE;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

FILE: design/sppt_intf.sv
// sppt_req_if / sppt_res_if: valid-ready stream channels of the tracker.
// Depends on sppt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sppt_req_if
  import sppt_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [CHAR_WIDTH-1:0]        command_char;
  logic signed [IN_WIDTH-1:0]   value;

  modport source (output valid, output op, output command_char, output value, input ready);
  modport sink   (input valid, input op, input command_char, input value, output ready);
endinterface

interface sppt_res_if
  import sppt_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [OUT_WIDTH-1:0]  point_x;
  logic signed [OUT_WIDTH-1:0]  point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

FILE: design/svg_path_point_tracker_core.sv
// svg_path_point_tracker_core: top level of the svg path point tracker.
// Depends on sppt_pkg, sppt_intf (req/res channels) and sppt_point_unit.
//
//  channel | dir | modport           | payload
//  req_i   | in  | sppt_req_if.sink  | op, command_char, value (Q16.16)
//  res_o   | out | sppt_res_if.source| point_x, point_y (Q16.16, saturated)
//
// one request per cycle sustained while no stalled result holds back a request that makes a point
// a point passes one input register, then one result register, around the point unit
// reset clears the last point, held x, parameter count and command class
// a stalled result holds the result register; the input register still empties
// for requests that make no point, so commands keep flowing under a stall
`timescale 1ns / 1ps
`default_nettype none

module svg_path_point_tracker_core
  import sppt_pkg::*;
#(
  parameter int unsigned CoordWidth = COORD_WIDTH_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  sppt_req_if.sink     req_i,
  sppt_res_if.source   res_o
);

  localparam int unsigned EW = (CoordWidth > IN_WIDTH) ? CoordWidth : IN_WIDTH;
  localparam logic signed [EW-1:0] CMAX =
    EW'(signed'({1'b0, {(CoordWidth-1){1'b1}}}));
  localparam logic signed [EW-1:0] CMIN = ~CMAX;
  localparam logic signed [EW-1:0] OMAX =
    EW'(signed'({1'b0, {(OUT_WIDTH-1){1'b1}}}));
  localparam logic signed [EW-1:0] OMIN = ~OMAX;

  // input register
  logic                    s1_valid_q;
  logic                    s1_op_q;
  logic [CHAR_WIDTH-1:0]   s1_ch_q;
  logic [CoordWidth-1:0]   s1_val_q;

  // tracker state
  logic [CoordWidth-1:0]   last_x_q;
  logic [CoordWidth-1:0]   last_y_q;
  logic [CoordWidth-1:0]   held_q;
  logic [CNT_WIDTH-1:0]    cnt_q;
  cls_e                    cls_q;

  // result register
  logic                    out_valid_q;
  logic [OUT_WIDTH-1:0]    out_x_q;
  logic [OUT_WIDTH-1:0]    out_y_q;

  logic signed [EW-1:0]    val_ext;
  logic [CoordWidth-1:0]   val_clamped;
  sppt_ctrl_t              ctrl;
  sppt_step_t              step;
  logic [CoordWidth-1:0]   held_d;
  logic [CoordWidth-1:0]   nx;
  logic [CoordWidth-1:0]   ny;
  logic signed [EW-1:0]    nx_ext;
  logic signed [EW-1:0]    ny_ext;
  logic [OUT_WIDTH-1:0]    out_x_d;
  logic [OUT_WIDTH-1:0]    out_y_d;
  logic                    s1_emit;
  logic                    out_free;
  logic                    s1_fire;
  logic                    req_fire;

  // clamp the incoming value to the coordinate range
  assign val_ext = EW'(req_i.value);
  always_comb begin
    if (val_ext > CMAX) begin
      val_clamped = CMAX[CoordWidth-1:0];
    end else if (val_ext < CMIN) begin
      val_clamped = CMIN[CoordWidth-1:0];
    end else begin
      val_clamped = val_ext[CoordWidth-1:0];
    end
  end

  // point unit
  assign ctrl.cls = cls_q;
  assign ctrl.cnt = cnt_q;

  sppt_point_unit #(
    .CoordWidth (CoordWidth)
  ) u_point_unit (
    .ctrl_i    (ctrl),
    .held_i    (held_q),
    .last_x_i  (last_x_q),
    .last_y_i  (last_y_q),
    .value_i   (s1_val_q),
    .step_o    (step),
    .held_o    (held_d),
    .point_x_o (nx),
    .point_y_o (ny)
  );

  // clamp the point to the output field range
  assign nx_ext = EW'(signed'(nx));
  assign ny_ext = EW'(signed'(ny));
  always_comb begin
    if (nx_ext > OMAX) begin
      out_x_d = OMAX[OUT_WIDTH-1:0];
    end else if (nx_ext < OMIN) begin
      out_x_d = OMIN[OUT_WIDTH-1:0];
    end else begin
      out_x_d = nx_ext[OUT_WIDTH-1:0];
    end
    if (ny_ext > OMAX) begin
      out_y_d = OMAX[OUT_WIDTH-1:0];
    end else if (ny_ext < OMIN) begin
      out_y_d = OMIN[OUT_WIDTH-1:0];
    end else begin
      out_y_d = ny_ext[OUT_WIDTH-1:0];
    end
  end

  // handshake
  assign s1_emit     = (s1_op_q == OP_PARAM) && step.emit;
  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && (!s1_emit || out_free);
  assign req_i.ready = !s1_valid_q || s1_fire;
  assign req_fire    = req_i.valid && req_i.ready;

  assign res_o.valid   = out_valid_q;
  assign res_o.point_x = out_x_q;
  assign res_o.point_y = out_y_q;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_op_q  <= req_i.op;
      s1_ch_q  <= req_i.command_char;
      s1_val_q <= val_clamped;
    end
  end

  // tracker state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q <= '0;
      last_y_q <= '0;
      held_q   <= '0;
      cnt_q    <= '0;
      cls_q    <= CLS_IGNORE;
    end else if (s1_fire) begin
      if (s1_op_q == OP_COMMAND) begin
        cls_q <= classify(s1_ch_q);
        cnt_q <= '0;
      end else begin
        cnt_q  <= step.cnt;
        held_q <= held_d;
        if (step.emit) begin
          last_x_q <= nx;
          last_y_q <= ny;
        end
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit) begin
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/sppt_point_unit.sv
// sppt_point_unit: next point, held x and parameter count for one parameter.
// Pure combinational; depends on sppt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sppt_point_unit
  import sppt_pkg::*;
#(
  parameter int unsigned CoordWidth = COORD_WIDTH_DEF
) (
  input  sppt_ctrl_t             ctrl_i,
  input  logic [CoordWidth-1:0]  held_i,
  input  logic [CoordWidth-1:0]  last_x_i,
  input  logic [CoordWidth-1:0]  last_y_i,
  input  logic [CoordWidth-1:0]  value_i,
  output sppt_step_t             step_o,
  output logic [CoordWidth-1:0]  held_o,
  output logic [CoordWidth-1:0]  point_x_o,
  output logic [CoordWidth-1:0]  point_y_o
);

  localparam logic [CoordWidth-1:0] CMAX = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic [CoordWidth-1:0] CMIN = {1'b1, {(CoordWidth-1){1'b0}}};

  // signed add clamped to the coordinate range
  function automatic logic [CoordWidth-1:0] sat_add(logic [CoordWidth-1:0] a,
                                                    logic [CoordWidth-1:0] b);
    logic [CoordWidth:0] s;
    s = {a[CoordWidth-1], a} + {b[CoordWidth-1], b};
    if (s[CoordWidth] != s[CoordWidth-1]) begin
      return s[CoordWidth] ? CMIN : CMAX;
    end
    return s[CoordWidth-1:0];
  endfunction

  logic [CoordWidth-1:0]  x_addend;
  logic [CoordWidth-1:0]  sum_x;
  logic [CoordWidth-1:0]  sum_y;
  logic [CNT_WIDTH:0]     arc_next;

  // two shared saturating adders
  assign x_addend = (ctrl_i.cls == CLS_H_REL) ? value_i : held_i;
  assign sum_x    = sat_add(last_x_i, x_addend);
  assign sum_y    = sat_add(last_y_i, value_i);
  assign arc_next = {1'b0, ctrl_i.cnt} + {{CNT_WIDTH{1'b0}}, 1'b1};

  // per-class point update
  always_comb begin
    step_o.emit = 1'b0;
    step_o.cnt  = ctrl_i.cnt;
    held_o      = held_i;
    point_x_o   = last_x_i;
    point_y_o   = last_y_i;
    unique case (ctrl_i.cls)
      CLS_ABS_PAIR, CLS_REL_PAIR: begin
        if (ctrl_i.cnt == '0) begin
          held_o     = value_i;
          step_o.cnt = {{(CNT_WIDTH-1){1'b0}}, 1'b1};
        end else begin
          step_o.cnt  = '0;
          step_o.emit = 1'b1;
          point_x_o   = (ctrl_i.cls == CLS_ABS_PAIR) ? held_i  : sum_x;
          point_y_o   = (ctrl_i.cls == CLS_ABS_PAIR) ? value_i : sum_y;
        end
      end
      CLS_H_ABS: begin
        step_o.emit = 1'b1;
        point_x_o   = value_i;
      end
      CLS_H_REL: begin
        step_o.emit = 1'b1;
        point_x_o   = sum_x;
      end
      CLS_V_ABS: begin
        step_o.emit = 1'b1;
        point_y_o   = value_i;
      end
      CLS_V_REL: begin
        step_o.emit = 1'b1;
        point_y_o   = sum_y;
      end
      CLS_ARC_ABS, CLS_ARC_REL: begin
        if (ctrl_i.cnt == ARC_X_INDEX) begin
          held_o = value_i;
        end else if (ctrl_i.cnt == ARC_Y_INDEX) begin
          step_o.emit = 1'b1;
          point_x_o   = (ctrl_i.cls == CLS_ARC_ABS) ? held_i  : sum_x;
          point_y_o   = (ctrl_i.cls == CLS_ARC_ABS) ? value_i : sum_y;
        end
        step_o.cnt = (arc_next >= {1'b0, ARC_GROUP}) ? '0 : arc_next[CNT_WIDTH-1:0];
      end
      default: begin
        step_o.emit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/sppt_checker.sv
// sppt_checker: port-level assertions on the tracker top level, with its bind.
// Depends on svg_path_point_tracker_core and the sppt channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module sppt_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        req_valid_i,
  input wire        req_ready_i,
  input wire        req_op_i,
  input wire        res_valid_i,
  input wire        res_ready_i,
  input wire [31:0] res_x_i,
  input wire [31:0] res_y_i
);

  // a pending result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_x_i) && $stable(res_y_i))
    else $error("result point changed while stalled");

  // request side only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> res_valid_i && !res_ready_i)
    else $error("request stalled without a stalled result");

  // a fresh result comes from an accepted parameter request, via the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(req_valid_i && req_ready_i && req_op_i, 2))
    else $error("result without a matching parameter request");

endmodule

bind svg_path_point_tracker_core sppt_checker u_sppt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_op_i    (req_i.op),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_x_i     (res_o.point_x),
  .res_y_i     (res_o.point_y)
);

`default_nettype wire
